FILE: src/hnt_pkg.sv
// Shared types, codes and helpers for the held-note table with root snapping.
// No dependencies; imported by hnt_cell, hnt_snap and the top level.
`default_nettype none

package hnt_pkg;

	// One held note: channel, incoming note and the note that was sent for it
	typedef struct packed {
		logic [3:0] channel;
		logic [6:0] in_note;
		logic [6:0] out_note;
	} hnt_entry_t;

	// Input beat kinds
	localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
	localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
	localparam logic [1:0] MODE_FLUSH    = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_TRANSPOSE = 2'd0;
	localparam logic [1:0] REG_ROOT_LOW  = 2'd1;
	localparam logic [1:0] REG_ROOT_HIGH = 2'd2;

	// Register reset values
	localparam logic [7:0] TRANSPOSE_RST = 8'd0;
	localparam logic [6:0] ROOT_LOW_RST  = 7'd36;
	localparam logic [6:0] ROOT_HIGH_RST = 7'd47;

	localparam int unsigned PITCH_CLASSES = 12;

	// Pitch class of a 7-bit note: fold the upper bits (16 = 4 mod 12),
	// then at most one subtraction of 12, 24 or 36.
	function automatic logic [3:0] pitch_class(input logic [6:0] v);
		logic [5:0] r;
		begin
			r = {1'b0, v[6:4], 2'b00} + {2'b00, v[3:0]};
			if (r >= 6'd36) begin
				r = r - 6'd36;
			end else if (r >= 6'd24) begin
				r = r - 6'd24;
			end else if (r >= 6'(PITCH_CLASSES)) begin
				r = r - 6'(PITCH_CLASSES);
			end
			return r[3:0];
		end
	endfunction

endpackage

`default_nettype wire

FILE: src/held_note_table_with_root_snap.sv
// Held-note table: a ring of MAX_HELD cells rotated past a head position.
// Note-on: clamp and snap stages, a full ring pass, then its result beats. Note-off: a full ring
// pass, then its beat if the note was held. Flush emits one beat per held note during its pass.
// A new input beat is taken only in idle, after the ring pass and result beats of the last one;
// output stalls hold the flush pass and the result beats. A beat of an unused mode is dropped in idle.
// Reset: held count cleared, registers to defaults; cell contents undefined, no clear pass.
`default_nettype none

module held_note_table_with_root_snap
	import hnt_pkg::*;
#(
	parameter int MAX_HELD = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration writes
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_idx,
	input  wire  [7:0]  cfg_wdata,
	// input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,  // channel[3:0], note[10:4], velocity[17:11], zero
	input  wire  [1:0]  s_axis_tuser,  // mode[1:0]
	// output stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_channel[3:0], out_note[10:4], out_velocity[17:11], zero
	output logic [0:0]  m_axis_tuser,  // is_note_on[0]
	output logic        m_axis_tlast
);

	localparam int STEP_W   = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
	localparam int CNT_W    = $clog2(MAX_HELD + 1);
	localparam int NEXT_IDX = (MAX_HELD > 1) ? 1 : 0;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_HELD - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLAMP = 3'd1;
	localparam logic [2:0] S_SNAP  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_OFF   = 3'd4;
	localparam logic [2:0] S_ON    = 3'd5;

	logic [2:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [1:0]        mode_q;
	logic [3:0]        ch_q;
	logic [6:0]        note_q;
	logic [6:0]        vel_q;
	logic              found_q;
	logic              appended_q;
	logic [6:0]        old_note_q;
	logic [6:0]        new_note_q;
	logic [7:0]        transpose_q;
	logic [6:0]        root_low_q;
	logic [6:0]        root_high_q;

	logic              out_valid_q;
	logic              out_on_q;
	logic [3:0]        out_ch_q;
	logic [6:0]        out_note_q;
	logic [6:0]        out_vel_q;
	logic              out_last_q;

	hnt_entry_t        cell_q   [MAX_HELD];
	hnt_entry_t        cell_din [MAX_HELD];
	logic [MAX_HELD-1:0] cell_hit;
	hnt_entry_t        head;
	hnt_entry_t        tail_in;
	logic [6:0]        snapped;

	logic              is_on, is_off, is_flush;
	logic              in_range;
	logic              match_now, append_now;
	logic              snap_pick;
	logic [6:0]        newo_now;
	logic              out_free;
	logic              flush_emit;
	logic              step_go;
	logic              pass_end;
	logic              found_fin, app_fin;
	logic              emit;
	logic              e_on;
	logic [3:0]        e_ch;
	logic [6:0]        e_note;
	logic [6:0]        e_vel;
	logic              e_last;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transpose_q <= TRANSPOSE_RST;
			root_low_q  <= ROOT_LOW_RST;
			root_high_q <= ROOT_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TRANSPOSE: transpose_q <= cfg_wdata;
				REG_ROOT_LOW:  root_low_q  <= cfg_wdata[6:0];
				REG_ROOT_HIGH: root_high_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// Transpose/snap unit, result registered through its clamp and snap stages, ready when the ring pass starts
	hnt_snap u_snap (
		.clk       (clk),
		.note      (note_q),
		.transpose (transpose_q),
		.root_low  (root_low_q),
		.root_high (root_high_q),
		.snapped   (snapped)
	);

	// Ring of cells: each takes its neighbor, the last one takes the head path
	for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
		if (i == MAX_HELD - 1) begin : g_tail
			assign cell_din[i] = tail_in;
		end else begin : g_mid
			assign cell_din[i] = cell_q[i+1];
		end
		hnt_cell u_cell (
			.clk         (clk),
			.shift       (step_go),
			.din         (cell_din[i]),
			.key_channel (ch_q),
			.key_note    (note_q),
			.entry       (cell_q[i]),
			.hit         (cell_hit[i])
		);
	end

	assign head = cell_q[0];

	// Head decode for the current step of the pass
	assign is_on    = (mode_q == MODE_NOTE_ON);
	assign is_off   = (mode_q == MODE_NOTE_OFF);
	assign is_flush = (mode_q == MODE_FLUSH);
	assign in_range = CNT_W'(step_q) < cnt_q;
	assign out_free = !out_valid_q || m_axis_tready;

	assign match_now  = (state_q == S_SCAN) && in_range && cell_hit[0] && !found_q
		&& (is_on || is_off);
	assign append_now = (state_q == S_SCAN) && is_on && !found_q
		&& (CNT_W'(step_q) == cnt_q);

	// Lone held note after the note-on gets the snapped value
	assign snap_pick = match_now ? (cnt_q == CNT_W'(1)) : (cnt_q == '0);
	assign newo_now  = snap_pick ? snapped : note_q;

	assign flush_emit = (state_q == S_SCAN) && is_flush && in_range;
	assign step_go    = (state_q == S_SCAN) && (!flush_emit || out_free);
	assign pass_end   = step_go && (step_q == STEP_LAST);
	assign found_fin  = found_q || match_now;
	assign app_fin    = appended_q || append_now;

	// What re-enters the ring at the tail
	always_comb begin
		tail_in = head;
		if (is_off && found_fin) begin
			// removal: skip the matched entry, later ones move up one place
			tail_in = cell_q[NEXT_IDX];
		end else if (is_on && match_now) begin
			tail_in.out_note = newo_now;
		end else if (append_now) begin
			tail_in.channel  = ch_q;
			tail_in.in_note  = note_q;
			tail_in.out_note = newo_now;
		end
	end

	// Result beat selection
	always_comb begin
		emit   = 1'b0;
		e_on   = 1'b0;
		e_ch   = ch_q;
		e_note = old_note_q;
		e_vel  = 7'd0;
		e_last = 1'b0;
		if (flush_emit && out_free) begin
			emit   = 1'b1;
			e_ch   = head.channel;
			e_note = head.out_note;
			e_last = (CNT_W'(step_q) + CNT_W'(1)) == cnt_q;
		end else if ((state_q == S_OFF) && out_free) begin
			emit   = 1'b1;
			e_last = is_off;
		end else if ((state_q == S_ON) && out_free) begin
			emit   = 1'b1;
			e_on   = 1'b1;
			e_note = new_note_q;
			e_vel  = vel_q;
			e_last = 1'b1;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			cnt_q      <= '0;
			found_q    <= 1'b0;
			appended_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						step_q     <= '0;
						found_q    <= 1'b0;
						appended_q <= 1'b0;
						case (s_axis_tuser)
							MODE_NOTE_ON:  state_q <= S_CLAMP;
							MODE_NOTE_OFF: state_q <= S_SCAN;
							MODE_FLUSH:    state_q <= S_SCAN;
							default:       state_q <= S_IDLE;
						endcase
					end
				end
				S_CLAMP: state_q <= S_SNAP;
				S_SNAP:  state_q <= S_SCAN;
				S_SCAN: begin
					if (step_go) begin
						if (match_now) begin
							found_q <= 1'b1;
						end
						if (append_now) begin
							appended_q <= 1'b1;
						end
					end
					if (pass_end) begin
						step_q <= '0;
						if (is_flush) begin
							cnt_q   <= '0;
							state_q <= S_IDLE;
						end else if (found_fin) begin
							if (is_off) begin
								cnt_q <= cnt_q - CNT_W'(1);
							end
							state_q <= S_OFF;
						end else if (app_fin) begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= S_ON;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (step_go) begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_OFF: begin
					if (out_free) begin
						state_q <= is_on ? S_ON : S_IDLE;
					end
				end
				S_ON: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Captured input beat and notes found during the pass
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_q <= s_axis_tuser;
			ch_q   <= s_axis_tdata[3:0];
			note_q <= s_axis_tdata[10:4];
			vel_q  <= s_axis_tdata[17:11];
		end
		if (match_now) begin
			old_note_q <= head.out_note;
		end
		if (match_now || append_now) begin
			new_note_q <= newo_now;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_on_q   <= e_on;
			out_ch_q   <= e_ch;
			out_note_q <= e_note;
			out_vel_q  <= e_vel;
			out_last_q <= e_last;
		end
	end

	assign s_axis_tready   = (state_q == S_IDLE);
	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {6'b000000, out_vel_q, out_note_q, out_ch_q};
	assign m_axis_tuser[0] = out_on_q;
	assign m_axis_tlast    = out_last_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_HELD))
		else $error("held count above table size");

	a_pass_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && step_go && (step_q != STEP_LAST) |=> (state_q == S_SCAN))
		else $error("ring pass left early");

	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pass_end && is_flush |=> (cnt_q == '0))
		else $error("flush left entries held");

	a_off_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OFF) |-> found_q)
		else $error("note-off sent without a held entry");

	a_on_source: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ON) |-> (found_q || appended_q) && is_on)
		else $error("note-on sent without a table entry");
`endif

endmodule

`default_nettype wire

FILE: src/hnt_cell.sv
// One cell of the held-note ring: holds a table entry, takes its neighbor's
// entry on a shift and compares its entry against the search key. Uses hnt_pkg.
`default_nettype none

module hnt_cell
	import hnt_pkg::*;
(
	input  wire        clk,
	input  wire        shift,
	input  wire hnt_entry_t din,
	input  wire  [3:0] key_channel,
	input  wire  [6:0] key_note,
	output hnt_entry_t entry,
	output logic       hit
);

	hnt_entry_t entry_q;

	// Entry storage, moves one place along the ring per shift
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= din;
		end
	end

	// Key compare on channel and incoming note
	assign hit   = (entry_q.channel == key_channel) && (entry_q.in_note == key_note);
	assign entry = entry_q;

endmodule

`default_nettype wire

FILE: src/hnt_snap.sv
// Two-stage unit: transpose with clamping to 0..127, then snap to the first
// note of the same pitch class in the root range. Uses hnt_pkg.
`default_nettype none

module hnt_snap
	import hnt_pkg::*;
(
	input  wire        clk,
	input  wire  [6:0] note,
	input  wire  [7:0] transpose,
	input  wire  [6:0] root_low,
	input  wire  [6:0] root_high,
	output logic [6:0] snapped
);

	logic signed [8:0] sum;
	logic        [6:0] clamp_s1;
	logic        [3:0] pc;
	logic        [3:0] low_pc;
	logic        [3:0] pc_gap;
	logic        [7:0] cand;
	logic        [6:0] snap_s2;

	// Stage 1: signed add and clamp
	assign sum = $signed({2'b00, note}) + $signed({transpose[7], transpose});

	always_ff @(posedge clk) begin
		if (sum[8]) begin
			clamp_s1 <= 7'd0;
		end else if (sum[7]) begin
			clamp_s1 <= 7'd127;
		end else begin
			clamp_s1 <= sum[6:0];
		end
	end

	// Stage 2: distance from root_low to the matching pitch class
	assign pc     = pitch_class(clamp_s1);
	assign low_pc = pitch_class(root_low);

	always_comb begin
		if (pc >= low_pc) begin
			pc_gap = pc - low_pc;
		end else begin
			pc_gap = pc + 4'(PITCH_CLASSES) - low_pc;
		end
	end

	assign cand = {1'b0, root_low} + {4'b0000, pc_gap};

	// Out of range (or reversed range) falls back to root_low
	always_ff @(posedge clk) begin
		if (cand <= {1'b0, root_high}) begin
			snap_s2 <= cand[6:0];
		end else begin
			snap_s2 <= root_low;
		end
	end

	assign snapped = snap_s2;

endmodule

`default_nettype wire
